>>> rtl/vwct_pkg.sv
// ----------------------------------------------------------------------------
// vwct_pkg
// Shared widths, register indexes, geometry bundles and the Q16.16 saturation
// used by the voxel/world coordinate transform.
// ----------------------------------------------------------------------------
package vwct_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_GEOM_SET = 3'd0;
    localparam logic [2:0] REG_SPACING  = 3'd1;
    localparam logic [2:0] REG_ORIGIN_X = 3'd2;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd3;
    localparam logic [2:0] REG_ORIGIN_Z = 3'd4;
    localparam logic [2:0] REG_DIR_ROW0 = 3'd5;
    localparam logic [2:0] REG_DIR_ROW1 = 3'd6;
    localparam logic [2:0] REG_DIR_ROW2 = 3'd7;

    localparam int CFG_W  = 60;   // widest register
    localparam int WADJ   = 33;   // adjugate entry, signed
    localparam int WMSP   = 36;   // direction entry times spacing, signed
    localparam int WDEN   = 68;   // |det| * |spacing|, unsigned
    localparam int WN     = 104;  // divider dividend and remainder
    localparam int QB     = 32;   // quotient bits produced by the divider
    localparam int NSTG   = 38;   // lane pipeline stages

    // per-lane geometry, derived from the configuration registers
    typedef struct packed {
        logic [2:0][WADJ-1:0] adj;      // adjugate row of this lane
        logic [2:0][WMSP-1:0] msp;      // direction row times spacing
        logic [31:0]          org_own;  // origin of this lane's axis
        logic [WDEN-1:0]      den;      // |det| * |spacing of this axis|
        logic                 sp_neg;   // spacing of this axis is negative
    } lgeom_t;

    // geometry shared by all lanes
    typedef struct packed {
        logic [2:0][31:0] org;
        logic             gset;
        logic             sp_zero;
        logic             det_zero;
        logic             det_neg;
    } gshared_t;

    // one lane's finished coordinate
    typedef struct packed {
        logic        err;
        logic [31:0] value;
    } lres_t;

    // sign and magnitude to signed Q16.16, clamped at both ends
    function automatic logic [31:0] sat_q16(input logic neg, input logic big,
                                            input logic [31:0] m);
        logic [31:0] r;
        if (neg)
        begin
            if (big || (m > 32'h8000_0000))
                r = 32'h8000_0000;
            else
                r = ~m + 32'd1;
        end
        else
        begin
            if (big || m[31])
                r = 32'h7FFF_FFFF;
            else
                r = m;
        end
        return r;
    endfunction

endpackage

>>> rtl/vwct_geom.sv
// ----------------------------------------------------------------------------
// vwct_geom
// Configuration registers and the geometry derived from them: adjugate,
// direction times spacing, determinant and the per-axis divisors.
// ----------------------------------------------------------------------------
module vwct_geom
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [2:0]                        cfg_index,
    input  logic [vwct_pkg::CFG_W-1:0]        cfg_data,
    output vwct_pkg::lgeom_t [2:0]            lg,
    output vwct_pkg::gshared_t                gs
);
    import vwct_pkg::*;

    logic               gset_reg;
    logic [59:0]        sp_reg;
    logic [2:0][31:0]   org_reg;
    logic [2:0][47:0]   dir_reg;

    logic signed [15:0]     m [3][3];
    logic signed [19:0]     sp [3];
    logic [19:0]            sp_mag [3];
    logic signed [31:0]     cp_a [3][3];
    logic signed [31:0]     cp_b [3][3];
    logic signed [WADJ-1:0] adj_next [3][3];
    logic signed [WADJ-1:0] adj_reg [3][3];
    logic signed [WMSP-1:0] msp_next [3][3];
    logic signed [WMSP-1:0] msp_reg [3][3];
    logic signed [50:0]     det_next;
    logic signed [50:0]     det_reg;
    logic [50:0]            det_abs;
    logic [WDEN-1:0]        den_next [3];
    logic [WDEN-1:0]        den_reg [3];

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gset_reg <= 1'b0;
            sp_reg   <= '0;
            org_reg  <= '0;
            dir_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GEOM_SET: gset_reg   <= cfg_data[0];
                REG_SPACING:  sp_reg     <= cfg_data[59:0];
                REG_ORIGIN_X: org_reg[0] <= cfg_data[31:0];
                REG_ORIGIN_Y: org_reg[1] <= cfg_data[31:0];
                REG_ORIGIN_Z: org_reg[2] <= cfg_data[31:0];
                REG_DIR_ROW0: dir_reg[0] <= cfg_data[47:0];
                REG_DIR_ROW1: dir_reg[1] <= cfg_data[47:0];
                REG_DIR_ROW2: dir_reg[2] <= cfg_data[47:0];
                default: ;
            endcase
        end
    end

    // unpack matrix and spacings
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sp[i]     = sp_reg[20*i +: 20];
            sp_mag[i] = sp[i][19] ? (~sp_reg[20*i +: 20] + 20'd1) : sp_reg[20*i +: 20];
            for (int j = 0; j < 3; j++)
                m[i][j] = dir_reg[i][16*j +: 16];
        end
    end

    // cofactors and direction times spacing
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                cp_a[i][j] = m[(j == 2) ? 0 : j + 1][(i == 2) ? 0 : i + 1]
                           * m[(j == 0) ? 2 : j - 1][(i == 0) ? 2 : i - 1];
                cp_b[i][j] = m[(j == 2) ? 0 : j + 1][(i == 0) ? 2 : i - 1]
                           * m[(j == 0) ? 2 : j - 1][(i == 2) ? 0 : i + 1];
                adj_next[i][j] = {cp_a[i][j][31], cp_a[i][j]}
                               - {cp_b[i][j][31], cp_b[i][j]};
                msp_next[i][j] = m[i][j] * sp[j];
            end
        end
    end

    // determinant from the first row and first adjugate column
    assign det_next = m[0][0] * adj_reg[0][0] + m[0][1] * adj_reg[1][0]
                    + m[0][2] * adj_reg[2][0];
    assign det_abs  = det_reg[50] ? (~det_reg + 51'd1) : det_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            den_next[i] = det_abs[47:0] * sp_mag[i];
    end

    // derived geometry, three register levels deep
    always_ff @(posedge clk)
    begin
        adj_reg <= adj_next;
        msp_reg <= msp_next;
        det_reg <= det_next;
        den_reg <= den_next;
    end

    // bundles for the lanes
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                lg[i].adj[j] = adj_reg[i][j];
                lg[i].msp[j] = msp_reg[i][j];
            end
            lg[i].org_own = org_reg[i];
            lg[i].den     = den_reg[i];
            lg[i].sp_neg  = sp[i][19];
        end
        gs.org      = org_reg;
        gs.gset     = gset_reg;
        gs.sp_zero  = (sp[0] == 20'sd0) || (sp[1] == 20'sd0) || (sp[2] == 20'sd0);
        gs.det_zero = (det_reg == 51'sd0);
        gs.det_neg  = det_reg[50];
    end

endmodule

>>> rtl/vwct_lane.sv
// ----------------------------------------------------------------------------
// vwct_lane
// One output axis: multiply-accumulate front end shared by both modes, then
// a pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module vwct_lane
(
    input  logic                        clk,
    input  logic [vwct_pkg::NSTG-1:0]   adv,
    input  logic                        mode,
    input  logic [2:0][31:0]            coord,
    input  vwct_pkg::lgeom_t            lg,
    input  vwct_pkg::gshared_t          gs,
    output vwct_pkg::lres_t             res
);
    import vwct_pkg::*;

    typedef struct packed {
        logic        mode;
        logic        err;
        logic        neg;
        logic        ovf;
        logic [31:0] res0;
    } side_t;

    // stage 0: input point and offsets from the origin
    logic                   s0_mode_reg;
    logic [2:0][31:0]       s0_c_reg;
    logic [2:0][32:0]       s0_dl_reg;
    // stage 1: products
    logic                   s1_mode_reg;
    logic signed [68:0]     s1_pr_reg [3];
    // stage 2: sign and magnitude of the sum
    side_t                  s2_sd_reg;
    logic [70:0]            s2_mag_reg;
    // stage 3: rounded mode 0 result and divider dividend
    side_t                  s3_sd_reg;
    logic [WN-1:0]          s3_n_reg;
    // divider stages, entry 0 is the overflow check
    side_t                  dv_sd_reg [QB+1];
    logic [WN-1:0]          dv_rem_reg [QB+1];
    logic [QB-1:0]          dv_q_reg [QB+1];
    // final stage
    lres_t                  fin_reg;

    logic signed [35:0]     a_op [3];
    logic signed [32:0]     b_op [3];
    logic signed [70:0]     sum_w;
    logic                   sum_neg;
    logic [71:0]            rnd;
    logic [WN-1:0]          n_next;
    logic [WN-1:0]          ovf_lim;

    // stage 0
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s0_mode_reg <= mode;
            s0_c_reg    <= coord;
            for (int j = 0; j < 3; j++)
                s0_dl_reg[j] <= {coord[j][31], coord[j]} - {gs.org[j][31], gs.org[j]};
        end
    end

    // operand select: adjugate times offset, or direction-spacing times voxel
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            a_op[j] = s0_mode_reg ? {{3{lg.adj[j][WADJ-1]}}, lg.adj[j]} : lg.msp[j];
            b_op[j] = s0_mode_reg ? s0_dl_reg[j] : {s0_c_reg[j][31], s0_c_reg[j]};
        end
    end

    // stage 1
    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s1_mode_reg <= s0_mode_reg;
            for (int j = 0; j < 3; j++)
                s1_pr_reg[j] <= a_op[j] * b_op[j];
        end
    end

    // sum of products plus origin in voxel-to-world direction
    assign sum_w = {{2{s1_pr_reg[0][68]}}, s1_pr_reg[0]}
                 + {{2{s1_pr_reg[1][68]}}, s1_pr_reg[1]}
                 + {{2{s1_pr_reg[2][68]}}, s1_pr_reg[2]}
                 + (s1_mode_reg ? 71'sd0
                                : {{9{lg.org_own[31]}}, lg.org_own, 30'b0});
    assign sum_neg = sum_w[70];

    // stage 2
    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            s2_sd_reg.mode <= s1_mode_reg;
            s2_sd_reg.err  <= !gs.gset || (s1_mode_reg && (gs.sp_zero || gs.det_zero));
            s2_sd_reg.neg  <= s1_mode_reg ? (sum_neg ^ gs.det_neg ^ lg.sp_neg) : sum_neg;
            s2_sd_reg.ovf  <= 1'b0;
            s2_sd_reg.res0 <= '0;
            s2_mag_reg     <= sum_neg ? (~sum_w + 71'd1) : sum_w;
        end
    end

    // round half away from zero, and form (2*num*2^30 + den)
    assign rnd    = {1'b0, s2_mag_reg} + 72'd536870912;
    assign n_next = {2'b0, s2_mag_reg, 31'b0} + {{(WN-WDEN){1'b0}}, lg.den};

    // stage 3
    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            s3_sd_reg <= '{mode: s2_sd_reg.mode,
                           err:  s2_sd_reg.err,
                           neg:  s2_sd_reg.neg,
                           ovf:  s2_sd_reg.ovf,
                           res0: sat_q16(s2_sd_reg.neg, |rnd[71:62], rnd[61:30])};
            s3_n_reg  <= n_next;
        end
    end

    // quotient of 2^32 or more saturates in either direction
    assign ovf_lim = {{(WN-WDEN-QB-1){1'b0}}, lg.den, {(QB+1){1'b0}}};

    // stage 4: overflow check
    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            dv_sd_reg[0]  <= '{mode: s3_sd_reg.mode,
                               err:  s3_sd_reg.err,
                               neg:  s3_sd_reg.neg,
                               ovf:  (s3_n_reg >= ovf_lim),
                               res0: s3_sd_reg.res0};
            dv_rem_reg[0] <= s3_n_reg;
            dv_q_reg[0]   <= '0;
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar g = 1; g <= QB; g++)
    begin : g_div
        localparam int K = QB - g;
        logic [WN-1:0] dsh;
        logic          take;

        assign dsh  = {{(WN-WDEN){1'b0}}, lg.den} << (K + 1);
        assign take = (dv_rem_reg[g-1] >= dsh);

        always_ff @(posedge clk)
        begin
            if (adv[4+g])
            begin
                dv_sd_reg[g]  <= dv_sd_reg[g-1];
                dv_rem_reg[g] <= take ? (dv_rem_reg[g-1] - dsh) : dv_rem_reg[g-1];
                dv_q_reg[g]   <= dv_q_reg[g-1] | (take ? (QB'(1) << K) : '0);
            end
        end
    end

    // final selection
    always_ff @(posedge clk)
    begin
        if (adv[NSTG-1])
        begin
            fin_reg.err <= dv_sd_reg[QB].err;
            if (dv_sd_reg[QB].err)
                fin_reg.value <= '0;
            else if (dv_sd_reg[QB].mode)
                fin_reg.value <= sat_q16(dv_sd_reg[QB].neg, dv_sd_reg[QB].ovf,
                                         dv_q_reg[QB]);
            else
                fin_reg.value <= dv_sd_reg[QB].res0;
        end
    end

    assign res = fin_reg;

endmodule

>>> rtl/voxel_world_coordinate_transform.sv
// ----------------------------------------------------------------------------
// voxel_world_coordinate_transform
// Maps a 3-D point between voxel and world space (Q16.16), one lane per axis.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------------
//   in      | to block  | in_valid/in_stall  | mode, coord_a, coord_b, coord_c
//   out     | from block| out_valid/out_stall| status, out_x, out_y, out_z
//   cfg     | to block  | cfg_we             | cfg_index, cfg_data
//
// One item per clock sustained while out_stall is low; an accepted item passes
// four front-end stages, an overflow check, the 32-stage quotient pipeline
// and a final select stage before out_valid.
// After a write, derived geometry settles through adj, det and den registers.
// Reset clears the configuration registers and every pipeline valid bit.
// A stalled output holds its item; stages behind it keep filling empty slots,
// so input stalls only once every stage holds an item.
// ----------------------------------------------------------------------------
module voxel_world_coordinate_transform
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [2:0]                  cfg_index,
    input  logic [vwct_pkg::CFG_W-1:0]  cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        mode,
    input  logic [31:0]                 coord_a,
    input  logic [31:0]                 coord_b,
    input  logic [31:0]                 coord_c,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        status,
    output logic [31:0]                 out_x,
    output logic [31:0]                 out_y,
    output logic [31:0]                 out_z
);
    import vwct_pkg::*;

    lgeom_t [2:0]       lg;
    gshared_t           gs;
    lres_t              lres [3];
    logic [2:0][31:0]   coord;

    logic [NSTG-1:0]    vld_reg;
    logic [NSTG-1:0]    vld_next;
    logic [NSTG:0]      rdy;
    logic               out_valid_reg;
    logic               status_reg;
    logic [31:0]        x_reg;
    logic [31:0]        y_reg;
    logic [31:0]        z_reg;

    // configuration and derived geometry
    vwct_geom u_geom
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .lg        (lg),
        .gs        (gs)
    );

    assign coord = {coord_c, coord_b, coord_a};

    // one lane per output axis
    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        vwct_lane u_lane
        (
            .clk   (clk),
            .adv   (rdy[NSTG-1:0]),
            .mode  (mode),
            .coord (coord),
            .lg    (lg[i]),
            .gs    (gs),
            .res   (lres[i])
        );
    end

    // a stage loads when it is empty or the stage after it moves on
    assign rdy[NSTG] = !out_valid_reg || !out_stall;
    for (genvar k = 0; k < NSTG; k++)
    begin : g_rdy
        assign rdy[k] = !vld_reg[k] || rdy[k+1];
    end

    assign in_stall = !rdy[0];

    always_comb
    begin
        for (int k = 0; k < NSTG; k++)
            vld_next[k] = rdy[k] ? ((k == 0) ? in_valid : vld_reg[(k == 0) ? 0 : k - 1])
                                 : vld_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
            if (rdy[NSTG])
                out_valid_reg <= vld_reg[NSTG-1];
        end
    end

    // merge the three lanes into the output item
    always_ff @(posedge clk)
    begin
        if (rdy[NSTG] && vld_reg[NSTG-1])
        begin
            status_reg <= lres[0].err;
            x_reg      <= lres[0].value;
            y_reg      <= lres[1].value;
            z_reg      <= lres[2].value;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;

    // an error item carries zero coordinates
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> (out_x == 32'd0) && (out_y == 32'd0) && (out_z == 32'd0))
        else $error("error item with non-zero coordinates");

    // an accepted item enters the first stage
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> vld_reg[0])
        else $error("accepted item lost at pipeline entry");

    // a finished item reaches the output register when it is free
    a_leave: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NSTG-1] && rdy[NSTG] |=> out_valid)
        else $error("finished item not presented");

    // all lanes agree on the error flag
    a_lane_err: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NSTG-1] |-> (lres[0].err == lres[1].err) && (lres[1].err == lres[2].err))
        else $error("lanes disagree on error");

endmodule
